/* rtl/dq_pkg.sv */
// Shared types and constants for the double-ended queue.
`default_nettype none
package dq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned KIND_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } dq_kind_type;

   // Decision taken for one accepted request.
   typedef struct packed {
      logic mem_write;
      logic mem_read;
      logic full_error;
      logic empty_error;
   } dq_op_type;

endpackage
`default_nettype wire

/* rtl/dq_ctrl.sv */
// Head, tail and occupancy registers of the queue and the per-request decision.
`default_nettype none
module dq_ctrl
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned CW = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [KIND_W-1:0] kind,
   output dq_op_type              op,
   output logic      [AW-1:0]     mem_addr,
   output logic      [CW-1:0]     occ_next
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] occ_ff;
   logic [AW-1:0] head_prev, head_next, tail_prev, tail_next;
   logic          is_full, is_empty;

   assign head_prev = (head_ff == '0)   ? LAST : head_ff - 1'b1;
   assign head_next = (head_ff == LAST) ? '0   : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0)   ? LAST : tail_ff - 1'b1;
   assign tail_next = (tail_ff == LAST) ? '0   : tail_ff + 1'b1;

   assign is_full  = (occ_ff == CW'(DEPTH));
   assign is_empty = (occ_ff == '0);

   always_comb begin
      op       = '0;
      mem_addr = head_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_next = occ_ff;
      unique case (dq_kind_type'(kind))
         KIND_PUSH_FRONT: begin
            if (is_full) begin
               op.full_error = 1'b1;
            end else begin
               op.mem_write = 1'b1;
               mem_addr     = head_prev;
               head_in      = head_prev;
               occ_next     = occ_ff + 1'b1;
            end
         end
         KIND_PUSH_BACK: begin
            if (is_full) begin
               op.full_error = 1'b1;
            end else begin
               op.mem_write = 1'b1;
               mem_addr     = tail_ff;
               tail_in      = tail_next;
               occ_next     = occ_ff + 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            if (is_empty) begin
               op.empty_error = 1'b1;
            end else begin
               op.mem_read = 1'b1;
               mem_addr    = head_ff;
               head_in     = head_next;
               occ_next    = occ_ff - 1'b1;
            end
         end
         KIND_POP_BACK: begin
            if (is_empty) begin
               op.empty_error = 1'b1;
            end else begin
               op.mem_read = 1'b1;
               mem_addr    = tail_prev;
               tail_in     = tail_prev;
               occ_next    = occ_ff - 1'b1;
            end
         end
         default: begin
            op = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (fire) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_next;
      end
   end

endmodule
`default_nettype wire

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: word memory, sequencer and response register.
`default_nettype none
// Double-ended queue of signed 32-bit words kept in a ring buffer of DEPTH
// words in one single-port synchronous memory. Each request pushes at the
// front or back, or pops from the front or back, and yields exactly one
// response carrying the popped word (zero for pushes and failed pops), an
// empty-error flag, a full-error flag and the count after the operation.
// A push on a full queue or a pop on an empty one changes nothing. For a push,
// and any failed request, the response is registered at the edge that accepts
// the request, where a push also writes its word. A successful pop passes
// through the registered read of the memory port and then the response
// register. The response register lets a new request enter while the
// previous response is being taken. Memory content has no reset; the queue
// reads only words it has written.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic        [KIND_W-1:0]  req_kind,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed      [VALUE_W-1:0] rsp_popped_value,
   output logic                           rsp_empty_error,
   output logic                           rsp_full_error,
   output logic             [COUNT_W-1:0] rsp_count
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // One-hot sequencer: IDLE takes requests, READ waits for the pop data.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                      req_fire;
   logic                      rsp_free;
   dq_op_type                 op;
   logic        [AW-1:0]      mem_addr;
   logic        [CW-1:0]      occ_next;

   // Word storage, read data registered.
   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] mem_q_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_popped_ff;
   logic                      rsp_empty_ff;
   logic                      rsp_full_ff;
   logic        [COUNT_W-1:0] rsp_count_ff;

   // The response slot is usable when empty or drained at this edge.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;

   dq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (req_fire),
      .kind     (req_kind),
      .op       (op),
      .mem_addr (mem_addr),
      .occ_next (occ_next)
   );

   // Single port: write for a push, read for a pop, never both.
   always_ff @(posedge clock) begin
      if (req_fire && op.mem_write) begin
         mem[mem_addr] <= req_value;
      end
      if (req_fire && op.mem_read) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (op.mem_read) begin
                  // Hold the response until the word comes back.
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            // Slot was freed when the pop was accepted.
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture flags and count at accept; the popped word follows in the cycle after.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_empty_ff  <= op.empty_error;
         rsp_full_ff   <= op.full_error;
         rsp_count_ff  <= COUNT_W'(occ_next);
         rsp_popped_ff <= '0;
      end else if (state_ff == ST_READ) begin
         rsp_popped_ff <= mem_q_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_empty_error  = rsp_empty_ff;
   assign rsp_full_error   = rsp_full_ff;
   assign rsp_count        = rsp_count_ff;

endmodule
`default_nettype wire
